### sv/fbbe_pkg.sv
package fbbe_pkg;

  // Table geometry
  localparam int SLOTS   = 256;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int PPB     = 4;
  localparam int PG_W    = $clog2(PPB);
  localparam int ADDR_W  = 32;
  localparam int BLK_W   = ADDR_W - PG_W;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = $clog2(PPB + 1);
  localparam int RES_W   = 9;

  localparam logic [RES_W-1:0] RES_MAX   = 9'd511;
  localparam logic [RES_W-1:0] CAP_RESET = 9'd256;

  // Request and result payloads
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] page_address;
    logic              is_write;
  } in_t;

  typedef struct packed {
    logic              evict_valid;
    logic [ADDR_W-1:0] evicted_address;
    logic              evicted_dirty;
    logic              last;
    logic              error;
  } out_t;

  // One slot of the block table
  typedef struct packed {
    logic [BLK_W-1:0]   blk;
    logic [PPB-1:0]     present;
    logic [PPB-1:0]     dirty;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

  // Controller to datapath
  typedef struct packed {
    logic in_load;
    logic scan_start;
    logic emit_load;
    logic emit_skip;
    logic commit;
    logic resp_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic evict;
    logic page_here;
    logic page_end;
    logic out_free;
  } sts_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [PPB-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < PPB; i++) begin
      c = c + CNT_W'(m[i]);
    end
    return c;
  endfunction

endpackage

### sv/fbbe_ctrl.sv
module fbbe_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fbbe_pkg::sts_t sts,
  output fbbe_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_EMIT   = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Sequencing of one request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load    = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = sts.evict ? ST_EMIT : ST_COMMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.page_here) begin
          cmd.emit_skip = 1'b1;
          if (sts.page_end) state_nxt = ST_COMMIT;
        end else if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.page_end) state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.evict ? ST_IDLE : ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/fbbe_dpath.sv
module fbbe_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fbbe_pkg::RES_W-1:0]    cfg_data,
  input  fbbe_pkg::in_t                 in_data,
  input  fbbe_pkg::cmd_t                cmd,
  output fbbe_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fbbe_pkg::out_t                out_data
);

  localparam int SLOT_W  = fbbe_pkg::SLOT_W;
  localparam int PPB     = fbbe_pkg::PPB;
  localparam int PG_W    = fbbe_pkg::PG_W;
  localparam int BLK_W   = fbbe_pkg::BLK_W;
  localparam int STAMP_W = fbbe_pkg::STAMP_W;
  localparam int CNT_W   = fbbe_pkg::CNT_W;
  localparam int RES_W   = fbbe_pkg::RES_W;

  // Request and configuration registers
  fbbe_pkg::in_t        req_r;
  logic [RES_W-1:0]     cap_r;
  logic [RES_W-1:0]     res_r, res_nxt;
  logic [STAMP_W-1:0]   clock_r;

  logic [BLK_W-1:0]     blk;
  logic [PG_W-1:0]      pg;
  logic [PPB-1:0]       bit_m;

  assign blk   = req_r.page_address[fbbe_pkg::ADDR_W-1:PG_W];
  assign pg    = req_r.page_address[PG_W-1:0];
  assign bit_m = {{(PPB-1){1'b0}}, 1'b1} << pg;

  always_ff @(posedge clk) begin
    if (cmd.in_load) req_r <= in_data;
  end

  // Slot table memory and valid bits
  fbbe_pkg::ent_t       mem_r [fbbe_pkg::SLOTS];
  fbbe_pkg::ent_t       rd_q_r;
  logic [fbbe_pkg::SLOTS-1:0] valid_r, valid_nxt;
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_idx;
  fbbe_pkg::ent_t       wr_ent;

  logic                 scan_act_r, pend_r, done_r;
  logic [SLOT_W-1:0]    cnt_r, idx_d_r;

  always_ff @(posedge clk) begin
    if (scan_act_r) rd_q_r <= mem_r[cnt_r];
    if (wr_en) mem_r[wr_idx] <= wr_ent;
  end

  // Scan sequencer: one table read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      pend_r     <= 1'b0;
      done_r     <= 1'b0;
      cnt_r      <= '0;
      idx_d_r    <= '0;
    end else begin
      pend_r  <= scan_act_r;
      idx_d_r <= cnt_r;
      done_r  <= pend_r && (idx_d_r == SLOT_W'(fbbe_pkg::SLOTS - 1));
      if (cmd.scan_start) begin
        cnt_r      <= '0;
        scan_act_r <= 1'b1;
      end else if (scan_act_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SLOT_W'(fbbe_pkg::SLOTS - 1)) scan_act_r <= 1'b0;
      end
    end
  end

  // Per-entry compare
  logic                 e_v, is_match, take_b, take_d;
  logic [STAMP_W-1:0]   age;
  logic [CNT_W-1:0]     e_cnt;

  logic                 m_found_r, f_found_r, b_found_r, d_found_r;
  logic [SLOT_W-1:0]    m_slot_r, f_slot_r, b_slot_r, d_slot_r;
  fbbe_pkg::ent_t       m_ent_r, b_ent_r, d_ent_r;
  logic [CNT_W-1:0]     b_cnt_r;
  logic [STAMP_W-1:0]   b_age_r, d_age_r;

  assign e_v      = valid_r[idx_d_r];
  assign age      = clock_r - rd_q_r.stamp;
  assign e_cnt    = fbbe_pkg::popcount(rd_q_r.present);
  assign is_match = e_v && (rd_q_r.blk == blk);
  assign take_b   = e_v && (!b_found_r || (e_cnt > b_cnt_r) ||
                            ((e_cnt == b_cnt_r) && (age > b_age_r)));
  assign take_d   = e_v && (&rd_q_r.dirty) && (!d_found_r || (age > d_age_r));

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      m_found_r <= 1'b0;
      f_found_r <= 1'b0;
      b_found_r <= 1'b0;
      d_found_r <= 1'b0;
    end else if (pend_r) begin
      if (is_match && !m_found_r) begin
        m_found_r <= 1'b1;
        m_slot_r  <= idx_d_r;
        m_ent_r   <= rd_q_r;
      end
      if (!e_v && !f_found_r) begin
        f_found_r <= 1'b1;
        f_slot_r  <= idx_d_r;
      end
      if (take_b) begin
        b_found_r <= 1'b1;
        b_slot_r  <= idx_d_r;
        b_ent_r   <= rd_q_r;
        b_cnt_r   <= e_cnt;
        b_age_r   <= age;
      end
      if (take_d) begin
        d_found_r <= 1'b1;
        d_slot_r  <= idx_d_r;
        d_ent_r   <= rd_q_r;
        d_age_r   <= age;
      end
    end
  end

  // Victim choice: oldest fully dirty block first, else the fullest, oldest among equals
  logic                 v_found, evict, m_keep, new_page;
  logic [SLOT_W-1:0]    v_slot, tgt;
  fbbe_pkg::ent_t       v_ent;
  logic [CNT_W-1:0]     v_cnt;
  logic [RES_W-1:0]     res_after;

  assign v_found = d_found_r || b_found_r;
  assign v_slot  = d_found_r ? d_slot_r : b_slot_r;
  assign v_ent   = d_found_r ? d_ent_r : b_ent_r;
  assign v_cnt   = fbbe_pkg::popcount(v_ent.present);
  assign evict   = req_r.kind && v_found &&
                   ((res_r >= cap_r) || (!m_found_r && !f_found_r));
  assign m_keep  = m_found_r && !(evict && (m_slot_r == v_slot));
  assign tgt     = (evict && (!f_found_r || (v_slot < f_slot_r))) ? v_slot : f_slot_r;
  assign new_page = m_keep ? !m_ent_r.present[pg] : 1'b1;

  // Page walk over the victim
  logic [PG_W-1:0]      pi_r;
  logic [PPB-1:0]       rest;

  assign rest = v_ent.present >> pi_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      pi_r <= '0;
    end else if (cmd.emit_load || cmd.emit_skip) begin
      pi_r <= pi_r + 1'b1;
    end
  end

  // Table update at commit
  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = m_slot_r;
    wr_ent    = m_ent_r;
    res_after = res_r;
    res_nxt   = res_r;
    if (cmd.commit) begin
      if (!req_r.kind) begin
        if (m_found_r) begin
          wr_en        = 1'b1;
          wr_ent.dirty = m_ent_r.dirty |
                         (req_r.is_write ? (bit_m & m_ent_r.present) : '0);
          wr_ent.stamp = clock_r;
        end
      end else begin
        if (evict) begin
          res_after = (res_r >= RES_W'(v_cnt)) ? res_r - RES_W'(v_cnt) : '0;
        end
        wr_en = 1'b1;
        if (m_keep) begin
          wr_ent.present = m_ent_r.present | bit_m;
          wr_ent.dirty   = m_ent_r.dirty | (req_r.is_write ? bit_m : '0);
        end else begin
          wr_idx         = tgt;
          wr_ent.blk     = blk;
          wr_ent.present = bit_m;
          wr_ent.dirty   = req_r.is_write ? bit_m : '0;
          wr_ent.stamp   = clock_r;
        end
        res_nxt = (new_page && (res_after < fbbe_pkg::RES_MAX)) ?
                  res_after + 1'b1 : res_after;
      end
    end
  end

  // Valid bits: victim dropped, new block taken
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.commit && req_r.kind) begin
      if (evict) valid_nxt[v_slot] = 1'b0;
      if (!m_keep) valid_nxt[tgt] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      clock_r <= '0;
      res_r   <= '0;
      cap_r   <= fbbe_pkg::CAP_RESET;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      res_r   <= res_nxt;
      valid_r <= valid_nxt;
      if (cmd.commit) begin
        if (!req_r.kind) begin
          if (m_found_r) clock_r <= clock_r + 1'b1;
        end else begin
          if (!m_keep) clock_r <= clock_r + 1'b1;
        end
      end
    end
  end

  // Output register
  logic                 out_valid_r;
  fbbe_pkg::out_t       out_r;
  logic                 out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load || cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_r.evict_valid     <= 1'b1;
      out_r.evicted_address <= {v_ent.blk, pi_r};
      out_r.evicted_dirty   <= v_ent.dirty[pi_r];
      out_r.last            <= (rest[PPB-1:1] == '0);
      out_r.error           <= 1'b0;
    end else if (cmd.resp_load) begin
      out_r.evict_valid     <= 1'b0;
      out_r.evicted_address <= '0;
      out_r.evicted_dirty   <= 1'b0;
      out_r.last            <= 1'b1;
      out_r.error           <= !req_r.kind && !m_found_r;
    end
  end

  assign sts.scan_done = done_r;
  assign sts.evict     = evict;
  assign sts.page_here = v_ent.present[pi_r];
  assign sts.page_end  = (pi_r == PG_W'(PPB - 1));
  assign sts.out_free  = out_free;

  // Checks
  a_emit_victim_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> valid_r[v_slot])
    else $error("eviction of an invalid slot");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load || cmd.resp_load) |-> out_free)
    else $error("result loaded over a waiting result");

  a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!scan_act_r && !pend_r))
    else $error("commit while the scan runs");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.in_load |-> (!scan_act_r && !pend_r && !done_r))
    else $error("request taken during a scan");

endmodule

### sv/flash_block_buffer_eviction.sv
// Flash-aware page buffer tracker with block-grained eviction.
// Input channel (in_valid / in_stall / in_data): one hit or miss request per
// page address; a request is taken when in_valid is high and in_stall low.
// Result channel (out_valid / out_stall / out_data): a hit gives one result;
// a miss gives one result per evicted page (dirty mark attached) or a single
// empty result, with last set on the final one.
// Configuration: cfg_we writes cfg_data into the capacity register; the user
// writes it only while no request is in flight, which the block does not enforce.
// Timing: every request walks the whole 256-slot table through the single
// registered read port of the slot memory, one slot a cycle, before its
// results are given. One request is handled at a time; in_stall stays
// high until it is finished. The last result waits in an output register,
// so the next request can be taken while it is stalled; a stalled receiver
// otherwise holds the block in its emit or response step.
// Reset (rst_n, synchronous): all slots invalid, recency clock and resident
// count zero, capacity 256. No clearing pass is needed.
module flash_block_buffer_eviction (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fbbe_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fbbe_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [fbbe_pkg::RES_W-1:0] cfg_data
);

  fbbe_pkg::cmd_t cmd;
  fbbe_pkg::sts_t sts;

  // Request sequencer
  fbbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot table, scan and result datapath
  fbbe_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/tb_flash_block_buffer_eviction.sv
`timescale 1ns / 100ps

module tb_flash_block_buffer_eviction;

  localparam int SLOTS  = fbbe_pkg::SLOTS;
  localparam int PPB    = fbbe_pkg::PPB;
  localparam int PG_W   = fbbe_pkg::PG_W;
  localparam int ADDR_W = fbbe_pkg::ADDR_W;
  localparam int BLK_W  = fbbe_pkg::BLK_W;
  localparam int RES_W  = fbbe_pkg::RES_W;
  localparam logic [RES_W-1:0] RES_MAX   = fbbe_pkg::RES_MAX;
  localparam logic [RES_W-1:0] CAP_RESET = fbbe_pkg::CAP_RESET;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES = 3000;

  typedef enum logic [1:0] {ROW_REQ, ROW_TYPED, ROW_CFG} row_kind_e;
  typedef enum logic {KIND_HIT = 1'b0, KIND_MISS = 1'b1} req_kind_e;

  typedef struct {
    row_kind_e        row;
    fbbe_pkg::in_t    req;
    logic [RES_W-1:0] cap;
    fbbe_pkg::out_t   want;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  fbbe_pkg::in_t    in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  fbbe_pkg::out_t   out_data;
  logic             cfg_we = 1'b0;
  logic [RES_W-1:0] cfg_data = CAP_RESET;

  flash_block_buffer_eviction DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Clock, period 8 ns
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Shadow copy of the block table
  logic             tbl_valid [SLOTS];
  logic [BLK_W-1:0] tbl_blk   [SLOTS];
  logic [PPB-1:0]   tbl_pres  [SLOTS];
  logic [PPB-1:0]   tbl_dirty [SLOTS];
  int               tbl_pcnt  [SLOTS];
  int               tbl_dcnt  [SLOTS];
  logic [31:0]      tbl_stamp [SLOTS];
  logic [31:0]      age_clock;
  logic [RES_W-1:0] resident;
  logic [RES_W-1:0] capacity;

  fbbe_pkg::out_t step_results[$];
  fbbe_pkg::out_t pending_results[$];
  row_t directed_rows[$];
  logic [BLK_W-1:0] block_pool[12];
  logic [31:0] recent_addr[$];

  int mismatches = 0;
  int cycles = 0;
  int idle_in = 0;
  int idle_out = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  // Throw out the oldest fully dirty block, else the fullest, oldest first
  function automatic void evict_victim();
    int victim, best_cnt, dvictim;
    logic [31:0] best_age, dage, age;
    victim = -1;
    best_cnt = -1;
    best_age = '0;
    dvictim = -1;
    dage = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[i]) continue;
      age = age_clock - tbl_stamp[i];
      if (tbl_dcnt[i] == PPB && (dvictim < 0 || age > dage)) begin
        dvictim = i;
        dage = age;
      end
      if (tbl_pcnt[i] > best_cnt || (tbl_pcnt[i] == best_cnt && age > best_age)) begin
        victim = i;
        best_cnt = tbl_pcnt[i];
        best_age = age;
      end
    end
    if (dvictim >= 0) victim = dvictim;
    if (victim < 0) return;
    for (int p = 0; p < PPB; p++) begin
      if (tbl_pres[victim][p]) begin
        step_results.push_back('{evict_valid: 1'b1,
                                 evicted_address: {tbl_blk[victim], PG_W'(p)},
                                 evicted_dirty: tbl_dirty[victim][p],
                                 last: 1'b0, error: 1'b0});
      end
    end
    if (int'(resident) >= tbl_pcnt[victim]) resident = resident - RES_W'(tbl_pcnt[victim]);
    else resident = '0;
    tbl_valid[victim] = 1'b0;
    tbl_pres[victim] = '0;
    tbl_dirty[victim] = '0;
    tbl_pcnt[victim] = 0;
    tbl_dcnt[victim] = 0;
  endfunction

  function automatic int find_block(input logic [BLK_W-1:0] b);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_blk[i] == b) return i;
    end
    return -1;
  endfunction

  // Expected results of one request, left in step_results
  function automatic void model_request(input fbbe_pkg::in_t r);
    logic [BLK_W-1:0] b;
    logic [PG_W-1:0] pg;
    int s, fs;
    b = r.page_address[ADDR_W-1:PG_W];
    pg = r.page_address[PG_W-1:0];
    step_results.delete();
    s = find_block(b);
    if (r.kind == KIND_HIT) begin
      if (s < 0) begin
        step_results.push_back('{1'b0, 32'd0, 1'b0, 1'b1, 1'b1});
        return;
      end
      if (r.is_write && tbl_pres[s][pg] && !tbl_dirty[s][pg]) begin
        tbl_dirty[s][pg] = 1'b1;
        tbl_dcnt[s]++;
      end
      tbl_stamp[s] = age_clock;
      age_clock++;
      step_results.push_back('{1'b0, 32'd0, 1'b0, 1'b1, 1'b0});
      return;
    end
    fs = -1;
    for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) fs = i;
    if (resident >= capacity || (s < 0 && fs < 0)) evict_victim();
    s = find_block(b);
    if (s < 0) begin
      fs = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) fs = i;
      s = fs;
      if (s >= 0) begin
        tbl_valid[s] = 1'b1;
        tbl_blk[s] = b;
        tbl_pres[s] = '0;
        tbl_dirty[s] = '0;
        tbl_pcnt[s] = 0;
        tbl_dcnt[s] = 0;
        tbl_stamp[s] = age_clock;
        age_clock++;
      end
    end
    if (s >= 0) begin
      if (!tbl_pres[s][pg]) begin
        tbl_pres[s][pg] = 1'b1;
        tbl_pcnt[s]++;
        if (resident < RES_MAX) resident++;
      end
      if (r.is_write && !tbl_dirty[s][pg]) begin
        tbl_dirty[s][pg] = 1'b1;
        tbl_dcnt[s]++;
      end
    end
    if (step_results.size() == 0) step_results.push_back('{1'b0, 32'd0, 1'b0, 1'b0, 1'b0});
    step_results[step_results.size()-1].last = 1'b1;
  endfunction

  // Offer one request; returns at the falling edge after it is taken
  task automatic send_request(input fbbe_pkg::in_t r, input logic typed,
                              input fbbe_pkg::out_t want);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    model_request(r);
    if (typed) pending_results.push_back(want);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
    if (r.kind == KIND_MISS) recent_addr.push_back(r.page_address);
    if (recent_addr.size() > 16) void'(recent_addr.pop_front());
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Capacity is written only with the block idle
  task automatic write_capacity(input logic [RES_W-1:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    capacity = v;
  endtask

  function automatic fbbe_pkg::in_t make_request(input int style);
    fbbe_pkg::in_t r;
    r.kind = $urandom_range(1);
    r.is_write = $urandom_range(1);
    if (style == 0) begin
      r.page_address = {block_pool[$urandom_range(11)], PG_W'($urandom_range(PPB - 1))};
    end else if ($urandom_range(99) < 80 || recent_addr.size() == 0) begin
      r.kind = KIND_MISS;
      r.page_address = $urandom;
    end else begin
      r.kind = KIND_HIT;
      r.page_address = recent_addr[$urandom_range(recent_addr.size() - 1)];
    end
    return r;
  endfunction

  function automatic void add_row(input row_kind_e k, input logic kind, input logic [31:0] a,
                                  input logic wr, input logic [RES_W-1:0] cap,
                                  input fbbe_pkg::out_t want);
    row_t rw;
    rw.row = k;
    rw.req = '{kind: kind, page_address: a, is_write: wr};
    rw.cap = cap;
    rw.want = want;
    directed_rows.push_back(rw);
  endfunction

  // Receiver: random stall, plus one long hold on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_out);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $realtime, out_data);
      end else begin
        if (out_data !== pending_results[0]) begin
          mismatches++;
          $display("%0t: result mismatch, expected %h, actual %h (valid dirty last error)",
                   $realtime, pending_results[0], out_data);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("flash_block_buffer_eviction: mismatch");
      $finish;
    end
  end

  localparam fbbe_pkg::out_t EMPTY_RES = '{1'b0, 32'd0, 1'b0, 1'b1, 1'b0};
  localparam fbbe_pkg::out_t ERROR_RES = '{1'b0, 32'd0, 1'b0, 1'b1, 1'b1};

  initial begin
    int phase_cap[4];
    int phase_items[4];
    int phase_style[4];
    fbbe_pkg::in_t r;

    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_blk[i] = '0;
      tbl_pres[i] = '0;
      tbl_dirty[i] = '0;
      tbl_pcnt[i] = 0;
      tbl_dcnt[i] = 0;
      tbl_stamp[i] = '0;
    end
    age_clock = '0;
    resident = '0;
    capacity = CAP_RESET;
    block_pool[0] = '0;
    block_pool[1] = '1;
    for (int i = 2; i < 12; i++) block_pool[i] = BLK_W'($urandom);

    // Directed requests; error and empty results typed in
    add_row(ROW_TYPED, KIND_HIT, 32'h0000_0010, 1'b0, '0, ERROR_RES);
    add_row(ROW_TYPED, KIND_MISS, 32'h0000_0000, 1'b1, '0, EMPTY_RES);
    add_row(ROW_TYPED, KIND_MISS, 32'hFFFF_FFFF, 1'b0, '0, EMPTY_RES);
    add_row(ROW_TYPED, KIND_HIT, 32'hFFFF_FFFF, 1'b1, '0, EMPTY_RES);
    // hit on an absent page of a tracked block
    add_row(ROW_TYPED, KIND_HIT, 32'hFFFF_FFFE, 1'b1, '0, EMPTY_RES);
    // miss on a page already present
    add_row(ROW_TYPED, KIND_MISS, 32'h0000_0000, 1'b0, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h0000_0001, 1'b0, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_HIT, 32'h0000_0001, 1'b1, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h0000_0002, 1'b1, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h0000_0003, 1'b1, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h0000_0104, 1'b0, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h0000_0105, 1'b0, '0, EMPTY_RES);
    // capacity 1: dirty block first, then the fullest
    add_row(ROW_CFG, 1'b0, '0, 1'b0, 9'd1, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h0000_0100, 1'b0, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h8000_0200, 1'b1, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h7FFF_FFFD, 1'b1, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_HIT, 32'h0000_0000, 1'b0, '0, EMPTY_RES);
    add_row(ROW_CFG, 1'b0, '0, 1'b0, 9'd3, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h7FFF_FFFC, 1'b1, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h7FFF_FFFE, 1'b1, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h7FFF_FFFF, 1'b1, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'h5555_5555, 1'b0, '0, EMPTY_RES);
    add_row(ROW_REQ, KIND_MISS, 32'hAAAA_AAAA, 1'b1, '0, EMPTY_RES);

    phase_cap = '{8, 256, 1, 37};
    phase_items = '{60, 190, 30, 30};
    phase_style = '{0, 1, 0, 0};

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_in = 25;
    idle_out = 53;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].row == ROW_CFG) write_capacity(directed_rows[i].cap);
      else send_request(directed_rows[i].req, directed_rows[i].row == ROW_TYPED,
                        directed_rows[i].want);
    end

    // Random phases, idling mode per phase
    for (int ph = 0; ph < 4; ph++) begin
      write_capacity(RES_W'(phase_cap[ph]));
      idle_in = (ph == 0) ? 25 : (ph == 1) ? 53 : 0;
      idle_out = (ph == 0) ? 53 : (ph == 1) ? 25 : 0;
      if (ph == 1) hold_req <= ~hold_req;
      for (int n = 0; n < phase_items[ph]; n++) begin
        if (ph == 0 && n == 30) drain();
        r = make_request(phase_style[ph]);
        send_request(r, 1'b0, EMPTY_RES);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("flash_block_buffer_eviction: match");
    end else begin
      $display("flash_block_buffer_eviction: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
sv/fbbe_pkg.sv
sv/fbbe_ctrl.sv
sv/fbbe_dpath.sv
sv/flash_block_buffer_eviction.sv
test/tb_flash_block_buffer_eviction.sv
